// ===== rtl/stki_pkg.sv =====
`default_nettype none
package stki_pkg;

    localparam int TABLE_DEPTH      = 64;
    localparam int TAG_BITS         = 16;
    localparam int IDX_W            = $clog2(TABLE_DEPTH);
    localparam int CNT_W            = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W            = (CNT_W > 7) ? CNT_W : 7;
    localparam int KEY_W            = 16;
    localparam int MAX_DAY          = 31;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MINUTES_PER_HOUR = 60;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_READ   = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_DAY   = 3'd1,
        ST_BAD_TIME  = 3'd2,
        ST_FULL      = 3'd3,
        ST_END       = 3'd4,
        ST_BAD_INDEX = 3'd5
    } t_status;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [5:0]          minute;
        logic [4:0]          hour;
        logic [4:0]          day;
    } t_entry;

    function automatic logic [KEY_W-1:0] key_of(input t_entry e);
        key_of = {e.day, e.hour, e.minute};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/stki_check.sv =====
`default_nettype none
module stki_check (
    input  var stki_pkg::t_action           i_action,
    input  var logic [5:0]                  i_day,
    input  var logic [5:0]                  i_hour,
    input  var logic [5:0]                  i_minute,
    input  var logic [5:0]                  i_read_index,
    input  var logic [stki_pkg::CNT_W-1:0]  i_count,
    output stki_pkg::t_status               o_status
);

    logic [stki_pkg::CMP_W-1:0] w_ridx;
    logic [stki_pkg::CMP_W-1:0] w_cnt;

    assign w_ridx = stki_pkg::CMP_W'(i_read_index);
    assign w_cnt  = stki_pkg::CMP_W'(i_count);

    // Checks run in priority order; the first that fails sets the status.
    always_comb begin
        priority if (i_action == stki_pkg::ACT_READ) begin
            o_status = (w_ridx >= w_cnt) ? stki_pkg::ST_BAD_INDEX : stki_pkg::ST_OK;
        end else if (i_count >= stki_pkg::CNT_W'(stki_pkg::TABLE_DEPTH)) begin
            o_status = stki_pkg::ST_FULL;
        end else if (i_day == 6'd0) begin
            o_status = stki_pkg::ST_END;
        end else if (i_day > 6'(stki_pkg::MAX_DAY)) begin
            o_status = stki_pkg::ST_BAD_DAY;
        end else if (i_hour >= 6'(stki_pkg::HOURS_PER_DAY) ||
                     i_minute >= 6'(stki_pkg::MINUTES_PER_HOUR)) begin
            o_status = stki_pkg::ST_BAD_TIME;
        end else begin
            o_status = stki_pkg::ST_OK;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sorted_time_key_insert_table.sv =====
`default_nettype none
// Channel  Dir  Handshake              Payload (low bit first)
// s        in   i_s_tvalid/o_s_tready  tdata: day, hour, minute, payload_tag, read_index
//                                      tuser: action
// m        out  o_m_tvalid/i_m_tready  tdata: status, position, entry_count, out_day,
//                                      out_hour, out_minute, out_tag
//
// One word at a time. A read passes S_READ_DATA and S_DONE to reach the output register;
// an insert walks the table down from the top, one memory read and one key compare per
// step, shifting each larger-or-equal entry up one slot until it meets a smaller key or
// reaches the bottom, then writes the new entry. Rejected words go straight to S_DONE.
// Input is taken only when the sequencer is idle; a finished word holds in the
// sequencer while the output register is still full.
// Reset empties the table at once; stored entries need no clearing.
module sorted_time_key_insert_table (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_s_tvalid,
    output logic            o_s_tready,
    input  var logic [39:0] i_s_tdata,  // day[5:0], hour[5:0], minute[5:0], payload_tag[15:0],
                                        // read_index[5:0]
    input  var logic        i_s_tuser,  // action
    output logic            o_m_tvalid,
    input  var logic        i_m_tready,
    output logic [47:0]     o_m_tdata   // status[2:0], position[5:0], entry_count[6:0],
                                        // out_day[4:0], out_hour[4:0], out_minute[5:0],
                                        // out_tag[15:0]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_DATA,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_WRITE_NEW,
        S_DONE
    } t_state;

    localparam int IW = stki_pkg::IDX_W;
    localparam int CW = stki_pkg::CNT_W;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic [IW-1:0]              r_j;
    stki_pkg::t_entry           r_new;
    stki_pkg::t_status          r_res_status;
    logic [IW-1:0]              r_res_pos;
    stki_pkg::t_entry           r_res_entry;
    logic                       r_o_valid;
    logic [47:0]                r_o_data;

    stki_pkg::t_entry           r_mem [stki_pkg::TABLE_DEPTH];
    stki_pkg::t_entry           r_rd_data;

    logic [IW-1:0]              w_rd_addr;
    logic                       w_we;
    logic [IW-1:0]              w_wr_addr;
    stki_pkg::t_entry           w_wr_data;
    logic                       w_accept;
    logic                       w_ge;
    logic                       w_out_free;
    stki_pkg::t_status          w_status;
    stki_pkg::t_action          w_action;
    stki_pkg::t_entry           w_in_entry;

    assign w_action   = stki_pkg::t_action'(i_s_tuser);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_o_valid || i_m_tready;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    assign w_in_entry.day    = i_s_tdata[4:0];
    assign w_in_entry.hour   = i_s_tdata[10:6];
    assign w_in_entry.minute = i_s_tdata[17:12];
    assign w_in_entry.tag    = stki_pkg::TAG_BITS'(i_s_tdata[33:18]);

    stki_check u_check (
        .i_action     (w_action),
        .i_day        (i_s_tdata[5:0]),
        .i_hour       (i_s_tdata[11:6]),
        .i_minute     (i_s_tdata[17:12]),
        .i_read_index (i_s_tdata[39:34]),
        .i_count      (r_count),
        .o_status     (w_status)
    );

    // Shared compare: stored key against the new key.
    assign w_ge = stki_pkg::key_of(r_rd_data) >= stki_pkg::key_of(r_new);

    always_comb begin
        w_rd_addr = IW'(r_j - 1'b1);
        if (r_state == S_IDLE) begin
            w_rd_addr = IW'(i_s_tdata[39:34]);
        end
    end

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_j;
        w_wr_data = r_new;
        unique case (r_state)
            S_SCAN_CMP: begin
                w_we      = w_ge;
                w_wr_data = r_rd_data;
            end
            S_WRITE_NEW: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_m_tready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_new        <= w_in_entry;
                        r_j          <= IW'(r_count);
                        r_res_status <= w_status;
                        r_res_pos    <= '0;
                        r_res_entry  <= '0;
                        if (w_status != stki_pkg::ST_OK) begin
                            r_state <= S_DONE;
                        end else if (w_action == stki_pkg::ACT_READ) begin
                            r_res_pos <= IW'(i_s_tdata[39:34]);
                            r_state   <= S_READ_DATA;
                        end else if (r_count == '0) begin
                            r_state <= S_WRITE_NEW;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_READ_DATA: begin
                    r_res_entry <= r_rd_data;
                    r_state     <= S_DONE;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    // Shift the larger-or-equal entry up one slot and keep walking down.
                    if (w_ge) begin
                        r_j <= IW'(r_j - 1'b1);
                        r_state <= (r_j == IW'(1)) ? S_WRITE_NEW : S_SCAN_RD;
                    end else begin
                        r_state <= S_WRITE_NEW;
                    end
                end
                S_WRITE_NEW: begin
                    r_count   <= CW'(r_count + 1'b1);
                    r_res_pos <= r_j;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= {16'(r_res_entry.tag), r_res_entry.minute,
                                      r_res_entry.hour, r_res_entry.day,
                                      7'(r_count), 6'(r_res_pos), r_res_status};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
